### rtl/lmn_pkg.sv
// Shared types, constants and helper functions for the Lamport mutex node.
// No dependencies; every other file refers to this package by scoped names.
package lmn_pkg;

    localparam int QDEPTH  = 16;
    localparam int CNT_W   = $clog2(QDEPTH + 1);
    localparam int TIME_W  = 15;
    localparam int ID_W    = 4;
    localparam int PC_W    = 5;
    localparam int CMD_W   = 3;
    localparam int KIND_W  = 2;
    localparam int ERR_W   = 2;
    localparam int SEEN_W  = 5;

    localparam logic [TIME_W-1:0] CLOCK_MAX   = '1;
    localparam logic [SEEN_W-1:0] SEEN_MAX    = '1;
    localparam logic [PC_W-1:0]   PEER_OFFSET = PC_W'(2);

    localparam logic [CMD_W-1:0] CMD_PEER_REQ  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PEER_REP  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEER_REL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEER_DONE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOCAL_REQ = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LOCAL_REL = 3'd5;

    localparam logic [KIND_W-1:0] KIND_NONE      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BCAST_REQ = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPLY     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BCAST_REL = 2'd3;

    localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL    = 2'd2;
    localparam logic [ERR_W-1:0] ERR_EMPTY   = 2'd3;

    localparam logic REG_OWN_ID     = 1'b0;
    localparam logic REG_PROC_COUNT = 1'b1;

    localparam logic [ID_W-1:0] OWN_ID_RST     = 4'd1;
    localparam logic [PC_W-1:0] PROC_COUNT_RST = 5'd3;

    typedef struct packed {
        logic load;
        logic commit;
    } t_ctrl;

    function automatic logic [TIME_W-1:0] clk_inc(input logic [TIME_W-1:0] c);
        return (c == CLOCK_MAX) ? CLOCK_MAX : c + TIME_W'(1);
    endfunction

    function automatic logic [SEEN_W-1:0] seen_inc(input logic [SEEN_W-1:0] c);
        return (c == SEEN_MAX) ? SEEN_MAX : c + SEEN_W'(1);
    endfunction

endpackage

### rtl/lmn_ctrl.sv
// Controller for the Lamport mutex node: accept/commit sequencing and result valid.
// Depends on lmn_pkg.
module lmn_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_valid,
    input  logic           i_m_ready,
    output logic           o_s_ready,
    output logic           o_m_valid,
    output lmn_pkg::t_ctrl o_ctrl
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;
    logic   out_free;

    assign out_free  = !r_m_valid || i_m_ready;
    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_m_valid;

    always_comb begin
        n_state       = r_state;
        o_ctrl.load   = 1'b0;
        o_ctrl.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    o_ctrl.commit = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_m_valid = r_m_valid;
        if (o_ctrl.commit) begin
            n_m_valid = 1'b1;
        end else if (i_m_ready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

endmodule

### rtl/lmn_dpath.sv
// Datapath for the Lamport mutex node: logical clock, sorted request queue,
// counters, configuration registers and result register. Depends on lmn_pkg.
module lmn_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lmn_pkg::t_ctrl               i_ctrl,
    input  logic [lmn_pkg::CMD_W-1:0]    i_cmd,
    input  logic [lmn_pkg::TIME_W-1:0]   i_msg_time,
    input  logic [lmn_pkg::ID_W-1:0]     i_sender_id,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [lmn_pkg::PC_W-1:0]     i_cfg_data,
    output logic [lmn_pkg::KIND_W-1:0]   o_send_kind,
    output logic [lmn_pkg::ID_W-1:0]     o_send_dest,
    output logic [lmn_pkg::TIME_W-1:0]   o_send_time,
    output logic                         o_granted,
    output logic                         o_all_done,
    output logic [lmn_pkg::ERR_W-1:0]    o_error_code
);

    localparam int QD = lmn_pkg::QDEPTH;

    logic [lmn_pkg::ID_W-1:0]   r_own_id;
    logic [lmn_pkg::PC_W-1:0]   r_proc_count;
    logic [lmn_pkg::TIME_W-1:0] r_clock, n_clock;
    logic [lmn_pkg::CNT_W-1:0]  r_count, n_count;
    logic [lmn_pkg::SEEN_W-1:0] r_replies, n_replies;
    logic [lmn_pkg::SEEN_W-1:0] r_dones, n_dones;

    logic [lmn_pkg::TIME_W-1:0] r_etime  [QD];
    logic [lmn_pkg::ID_W-1:0]   r_eowner [QD];
    logic [lmn_pkg::TIME_W-1:0] n_etime  [QD];
    logic [lmn_pkg::ID_W-1:0]   n_eowner [QD];
    logic [lmn_pkg::TIME_W-1:0] ins_time [QD];
    logic [lmn_pkg::ID_W-1:0]   ins_owner[QD];
    logic [lmn_pkg::TIME_W-1:0] pop_time [QD];
    logic [lmn_pkg::ID_W-1:0]   pop_owner[QD];

    logic [lmn_pkg::CMD_W-1:0]  r_cmd;
    logic [lmn_pkg::ID_W-1:0]   r_sender;
    logic [lmn_pkg::TIME_W-1:0] r_key_time;
    logic [lmn_pkg::ID_W-1:0]   r_key_owner;
    logic [QD-1:0]              r_le;
    logic [QD-1:0]              prev_le;

    logic [lmn_pkg::TIME_W-1:0] key_time;
    logic [lmn_pkg::ID_W-1:0]   key_owner;
    logic [QD-1:0]              le;
    logic [lmn_pkg::TIME_W-1:0] recv_max;
    logic                       is_local;

    logic [lmn_pkg::KIND_W-1:0] n_kind;
    logic [lmn_pkg::ID_W-1:0]   n_dest;
    logic [lmn_pkg::TIME_W-1:0] n_stime;
    logic [lmn_pkg::ERR_W-1:0]  n_err;
    logic [lmn_pkg::PC_W-1:0]   need;
    logic                       q_full;
    logic                       q_empty;

    assign is_local  = (i_cmd == lmn_pkg::CMD_LOCAL_REQ) || (i_cmd == lmn_pkg::CMD_LOCAL_REL);
    assign recv_max  = (r_clock > i_msg_time) ? r_clock : i_msg_time;
    assign key_time  = (i_cmd == lmn_pkg::CMD_LOCAL_REQ) ? lmn_pkg::clk_inc(r_clock) : i_msg_time;
    assign key_owner = (i_cmd == lmn_pkg::CMD_LOCAL_REQ) ? r_own_id : i_sender_id;

    always_comb begin
        for (int k = 0; k < QD; k++) begin
            le[k] = (lmn_pkg::CNT_W'(k) < r_count) &&
                    ((r_etime[k] < key_time) ||
                     ((r_etime[k] == key_time) && (r_eowner[k] <= key_owner)));
        end
    end

    assign prev_le = {r_le[QD-2:0], 1'b1};

    for (genvar g = 0; g < QD; g++) begin : g_lane
        logic [lmn_pkg::TIME_W-1:0] sh_time;
        logic [lmn_pkg::ID_W-1:0]   sh_owner;
        if (g == 0) begin : g_first
            assign sh_time  = r_key_time;
            assign sh_owner = r_key_owner;
        end else begin : g_rest
            assign sh_time  = r_etime[g-1];
            assign sh_owner = r_eowner[g-1];
        end
        if (g == QD - 1) begin : g_last
            assign pop_time[g]  = r_etime[g];
            assign pop_owner[g] = r_eowner[g];
        end else begin : g_mid
            assign pop_time[g]  = r_etime[g+1];
            assign pop_owner[g] = r_eowner[g+1];
        end
        always_comb begin
            if (r_le[g]) begin
                ins_time[g]  = r_etime[g];
                ins_owner[g] = r_eowner[g];
            end else if (prev_le[g]) begin
                ins_time[g]  = r_key_time;
                ins_owner[g] = r_key_owner;
            end else begin
                ins_time[g]  = sh_time;
                ins_owner[g] = sh_owner;
            end
        end
    end

    assign q_full  = (r_count == lmn_pkg::CNT_W'(QD));
    assign q_empty = (r_count == '0);
    assign need    = (r_proc_count >= lmn_pkg::PEER_OFFSET) ?
                     r_proc_count - lmn_pkg::PEER_OFFSET : '0;

    always_comb begin
        n_clock   = r_clock;
        n_count   = r_count;
        n_replies = r_replies;
        n_dones   = r_dones;
        n_etime   = r_etime;
        n_eowner  = r_eowner;
        n_kind    = lmn_pkg::KIND_NONE;
        n_dest    = '0;
        n_stime   = '0;
        n_err     = lmn_pkg::ERR_OK;
        unique case (r_cmd)
            lmn_pkg::CMD_PEER_REQ: begin
                if (q_full) begin
                    n_err = lmn_pkg::ERR_FULL;
                end else begin
                    n_etime  = ins_time;
                    n_eowner = ins_owner;
                    n_count  = r_count + lmn_pkg::CNT_W'(1);
                    n_clock  = lmn_pkg::clk_inc(r_clock);
                    n_kind   = lmn_pkg::KIND_REPLY;
                    n_dest   = r_sender;
                    n_stime  = n_clock;
                end
            end
            lmn_pkg::CMD_PEER_REP: begin
                n_replies = lmn_pkg::seen_inc(r_replies);
            end
            lmn_pkg::CMD_PEER_REL: begin
                if (q_empty) begin
                    n_err = lmn_pkg::ERR_EMPTY;
                end else begin
                    n_etime  = pop_time;
                    n_eowner = pop_owner;
                    n_count  = r_count - lmn_pkg::CNT_W'(1);
                end
            end
            lmn_pkg::CMD_PEER_DONE: begin
                n_dones = lmn_pkg::seen_inc(r_dones);
            end
            lmn_pkg::CMD_LOCAL_REQ: begin
                if (q_full) begin
                    n_err = lmn_pkg::ERR_FULL;
                end else begin
                    n_etime   = ins_time;
                    n_eowner  = ins_owner;
                    n_count   = r_count + lmn_pkg::CNT_W'(1);
                    n_clock   = r_key_time;
                    n_replies = '0;
                    n_kind    = lmn_pkg::KIND_BCAST_REQ;
                    n_stime   = r_key_time;
                end
            end
            lmn_pkg::CMD_LOCAL_REL: begin
                if (q_empty) begin
                    n_err = lmn_pkg::ERR_EMPTY;
                end else begin
                    n_etime  = pop_time;
                    n_eowner = pop_owner;
                    n_count  = r_count - lmn_pkg::CNT_W'(1);
                    n_clock  = lmn_pkg::clk_inc(r_clock);
                    n_kind   = lmn_pkg::KIND_BCAST_REL;
                    n_stime  = n_clock;
                end
            end
            default: n_err = lmn_pkg::ERR_UNKNOWN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id     <= lmn_pkg::OWN_ID_RST;
            r_proc_count <= lmn_pkg::PROC_COUNT_RST;
            r_clock      <= '0;
            r_count      <= '0;
            r_replies    <= '0;
            r_dones      <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == lmn_pkg::REG_OWN_ID) begin
                r_own_id <= i_cfg_data[lmn_pkg::ID_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == lmn_pkg::REG_PROC_COUNT) begin
                r_proc_count <= i_cfg_data;
            end
            if (i_ctrl.load && !is_local) begin
                r_clock <= lmn_pkg::clk_inc(recv_max);
            end
            if (i_ctrl.commit) begin
                r_clock   <= n_clock;
                r_count   <= n_count;
                r_replies <= n_replies;
                r_dones   <= n_dones;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd       <= i_cmd;
            r_sender    <= i_sender_id;
            r_key_time  <= key_time;
            r_key_owner <= key_owner;
            r_le        <= le;
        end
        if (i_ctrl.commit) begin
            r_etime      <= n_etime;
            r_eowner     <= n_eowner;
            o_send_kind  <= n_kind;
            o_send_dest  <= n_dest;
            o_send_time  <= n_stime;
            o_granted    <= (n_count != '0) && (n_eowner[0] == r_own_id) &&
                            (n_replies == need);
            o_all_done   <= (n_dones == need);
            o_error_code <= n_err;
        end
    end

endmodule

### rtl/lamport_mutex_node.sv
// Top level of one Lamport mutual exclusion node: controller plus datapath.
// Depends on lmn_pkg, lmn_ctrl and lmn_dpath.
//
//   channel   direction  beat contents
//   s_axis    in         tuser: cmd; tdata: msg_time, sender_id
//   m_axis    out        tuser: send_kind; tdata: dest, time, granted, all_done, error
//   cfg       in         index 0 own_id, index 1 process_count
//
// Per item, the accept cycle updates the clock on a peer message and registers the queue
// compare flags; the commit cycle shifts the queue and loads the result.
// One result register; the next beat is accepted while a result waits, and the
// commit cycle holds until that register is free.
// Synchronous active-low reset; the queue entries have no reset.
module lamport_mutex_node (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [14:0] msg_time, [18:15] sender_id
    input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [3:0] send_dest, [18:4] send_time,
                                        // [19] granted, [20] all_done, [22:21] error_code
    output logic [1:0]  m_axis_tuser,   // [1:0] send_kind
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [4:0]  i_cfg_data
);

    lmn_pkg::t_ctrl               ctrl;
    logic [lmn_pkg::ID_W-1:0]     send_dest;
    logic [lmn_pkg::TIME_W-1:0]   send_time;
    logic                         granted;
    logic                         all_done;
    logic [lmn_pkg::ERR_W-1:0]    error_code;

    assign o_cfg_ready = 1'b1;

    lmn_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_ctrl    (ctrl)
    );

    lmn_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_cmd        (s_axis_tuser),
        .i_msg_time   (s_axis_tdata[14:0]),
        .i_sender_id  (s_axis_tdata[18:15]),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_send_kind  (m_axis_tuser),
        .o_send_dest  (send_dest),
        .o_send_time  (send_time),
        .o_granted    (granted),
        .o_all_done   (all_done),
        .o_error_code (error_code)
    );

    assign m_axis_tdata = {1'b0, error_code, all_done, granted, send_time, send_dest};

endmodule

### rtl/lmn_checker.sv
// Port-level checker for lamport_mutex_node, attached by the bind below.
// Depends on lmn_pkg.
module lmn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second beat taken before commit");

    a_send_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != lmn_pkg::KIND_NONE |->
            m_axis_tdata[22:21] == lmn_pkg::ERR_OK && m_axis_tdata[18:4] != '0)
        else $error("send with error or zero time");

    a_dest_reply_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != lmn_pkg::KIND_REPLY |-> m_axis_tdata[3:0] == '0)
        else $error("destination set on non-reply");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind lamport_mutex_node lmn_checker u_lmn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
